// ===== src/codon_usage_counter_macros.svh =====
// Assertion helpers shared by the codon usage counter modules.
// Each expects signals named clk and arst_n in the scope where it is used.
`ifndef CODON_USAGE_COUNTER_MACROS_SVH
`define CODON_USAGE_COUNTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CUC_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked outside reset.
`define CUC_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== src/cuc_pkg.sv =====
package cuc_pkg;

	localparam int CNT_W   = 24;
	localparam int RD_W    = 7;
	localparam int NCODON  = 64;
	localparam int IDX_W   = 6;
	localparam int QPTR_W  = 2;
	localparam int QDEPTH  = 1 << QPTR_W;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;

	localparam logic [RD_W-1:0]    RARE_MAX        = RD_W'(NCODON);
	localparam logic [NCODON-1:0]  RARE_MASK_RESET = 64'hFFFF_FFFF_BFFF_FFFF;

	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_T = 8'h54;

	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		OP_REPORT = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	localparam logic KIND_TRIPLET = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	typedef struct packed {
		logic [1:0]       command;
		logic [7:0]       base_char;
		logic [IDX_W-1:0] bin_index;
	} item_t;

	typedef struct packed {
		logic             result_kind;
		logic [IDX_W-1:0] codon_index;
		logic             codon_valid;
		logic             codon_rare;
		logic [CNT_W-1:0] bin_count;
		logic [CNT_W-1:0] total_codons;
		logic [CNT_W-1:0] gc_count;
		logic [CNT_W-1:0] base_count;
		logic [RD_W-1:0]  rare_distinct;
	} result_t;

	// One unit of work handed from the front part to the back part.
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] addr;
		logic             codon_valid;
		logic             codon_rare;
		logic [CNT_W-1:0] total_codons;
		logic [CNT_W-1:0] gc_count;
		logic [CNT_W-1:0] base_count;
		logic [RD_W-1:0]  rare_distinct;
	} back_op_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
		return r;
	endfunction

endpackage

// ===== src/cuc_fifo.sv =====
`include "codon_usage_counter_macros.svh"

module cuc_fifo import cuc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  back_op_t wr_op,
	input  logic     pop,
	output back_op_t head,
	output logic     empty,
	output logic     full
);

	back_op_t           slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head  = slot_q[rd_ptr_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));

	`CUC_ASSERT_NOW(a_fifo_no_underflow, pop, cnt_q != '0, "queue popped while empty")
	`CUC_ASSERT_NOW(a_fifo_no_overflow, push && !pop, !full, "queue pushed while full")

endmodule

// ===== src/cuc_front.sv =====
`include "codon_usage_counter_macros.svh"

module cuc_front import cuc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  item_t             item,
	input  logic [NCODON-1:0] rare_mask,
	output logic              push,
	output back_op_t          wr_op
);

	phase_t             phase_q;
	phase_t             phase_n;
	logic [3:0]         part_q;
	logic               pval_q;
	logic [CNT_W-1:0]   tot_q;
	logic [CNT_W-1:0]   gc_q;
	logic [CNT_W-1:0]   chars_q;
	logic [RD_W-1:0]    rare_q;
	logic [NCODON-1:0]  seen_q;

	logic [1:0]         code;
	logic               ok;
	logic               is_gc;
	logic               valid_c;
	logic [IDX_W-1:0]   idx_c;
	logic               rare_c;
	logic               rare_inc;
	logic [CNT_W-1:0]   chars_n;
	logic [CNT_W-1:0]   gc_n;
	logic [CNT_W-1:0]   tot_n;
	logic [RD_W-1:0]    rare_n;
	logic               is_push;
	logic               is_clear;

	always_comb begin
		code = BASE_A;
		ok   = 1'b1;
		unique case (item.base_char)
			CH_A:    code = BASE_A;
			CH_C:    code = BASE_C;
			CH_G:    code = BASE_G;
			CH_T:    code = BASE_T;
			default: ok   = 1'b0;
		endcase
	end

	assign is_push  = accept && (item.command == CMD_PUSH);
	assign is_clear = accept && (item.command == CMD_CLEAR);
	assign is_gc    = (item.base_char == CH_G) || (item.base_char == CH_C);

	// Completion of the third character of a triplet.
	assign valid_c  = pval_q && ok;
	assign idx_c    = valid_c ? {part_q, code} : '0;
	assign rare_c   = valid_c && rare_mask[idx_c];
	assign rare_inc = rare_c && !seen_q[idx_c] && (rare_q < RARE_MAX);

	assign chars_n = sat_inc(chars_q);
	assign gc_n    = is_gc ? sat_inc(gc_q) : gc_q;
	assign tot_n   = valid_c ? sat_inc(tot_q) : tot_q;
	assign rare_n  = rare_inc ? rare_q + RD_W'(1) : rare_q;

	always_comb begin
		phase_n = phase_q;
		if (is_clear) begin
			phase_n = PH_FIRST;
		end else if (is_push) begin
			unique case (phase_q)
				PH_FIRST:  phase_n = PH_SECOND;
				PH_SECOND: phase_n = PH_THIRD;
				default:   phase_n = PH_FIRST;
			endcase
		end
	end

	always_comb begin
		push               = 1'b0;
		wr_op.op           = OP_REPORT;
		wr_op.addr         = idx_c;
		wr_op.codon_valid  = valid_c;
		wr_op.codon_rare   = rare_c;
		wr_op.total_codons = tot_n;
		wr_op.gc_count     = gc_n;
		wr_op.base_count   = chars_n;
		wr_op.rare_distinct = rare_n;
		if (accept) begin
			unique case (item.command)
				CMD_PUSH: begin
					push = (phase_q == PH_THIRD);
				end
				CMD_READ: begin
					push                = 1'b1;
					wr_op.op            = OP_READ;
					wr_op.addr          = item.bin_index;
					wr_op.codon_valid   = 1'b0;
					wr_op.codon_rare    = 1'b0;
					wr_op.total_codons  = tot_q;
					wr_op.gc_count      = gc_q;
					wr_op.base_count    = chars_q;
					wr_op.rare_distinct = rare_q;
				end
				CMD_CLEAR: begin
					push     = 1'b1;
					wr_op.op = OP_CLEAR;
				end
				default: push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			part_q  <= '0;
			pval_q  <= 1'b1;
			tot_q   <= '0;
			gc_q    <= '0;
			chars_q <= '0;
			rare_q  <= '0;
			seen_q  <= '0;
		end else begin
			phase_q <= phase_n;
			if (is_clear) begin
				part_q  <= '0;
				pval_q  <= 1'b1;
				tot_q   <= '0;
				gc_q    <= '0;
				chars_q <= '0;
				rare_q  <= '0;
				seen_q  <= '0;
			end else if (is_push) begin
				chars_q <= chars_n;
				gc_q    <= gc_n;
				unique case (phase_q)
					PH_FIRST: begin
						part_q <= {2'b00, code};
						pval_q <= ok;
					end
					PH_SECOND: begin
						part_q <= {part_q[1:0], code};
						pval_q <= pval_q && ok;
					end
					default: begin
						part_q <= '0;
						pval_q <= 1'b1;
						tot_q  <= tot_n;
						rare_q <= rare_n;
						if (valid_c) begin
							seen_q[idx_c] <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	`CUC_ASSERT_NEXT(a_front_clear_empties, is_clear, seen_q == '0, "clear left codons seen")

endmodule

// ===== src/cuc_back.sv =====
`include "codon_usage_counter_macros.svh"

module cuc_back import cuc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  back_op_t head,
	input  logic     empty,
	output logic     pop,
	output logic     result_valid,
	input  logic     result_ready,
	output result_t  result
);

	logic [CNT_W-1:0]   hist_mem [NCODON];
	logic [NCODON-1:0]  hist_vld_q;

	back_op_t           op_s2;
	logic               vld_s2;
	logic [CNT_W-1:0]   rd_s2;
	logic               rd_vld_s2;

	// Most recent change made to the bins, for the op that read alongside it.
	logic               last_clr_q;
	logic               last_upd_q;
	logic [IDX_W-1:0]   last_addr_q;
	logic [CNT_W-1:0]   last_data_q;

	result_t            res_q;
	logic               res_vld_q;

	logic               done_s2;
	logic               adv;
	logic               emits;
	logic               writes;
	logic [CNT_W-1:0]   cur_bin;
	logic [CNT_W-1:0]   new_bin;
	result_t            res_n;

	assign emits   = (op_s2.op != OP_CLEAR);
	assign writes  = (op_s2.op == OP_REPORT) && op_s2.codon_valid;
	assign done_s2 = vld_s2 && (!emits || !res_vld_q || result_ready);
	assign adv     = !vld_s2 || done_s2;
	assign pop     = adv && !empty;

	always_comb begin
		if (last_clr_q) begin
			cur_bin = '0;
		end else if (last_upd_q && (last_addr_q == op_s2.addr)) begin
			cur_bin = last_data_q;
		end else begin
			cur_bin = rd_vld_s2 ? rd_s2 : '0;
		end
	end

	assign new_bin = sat_inc(cur_bin);

	always_comb begin
		res_n.codon_index   = op_s2.addr;
		res_n.codon_valid   = op_s2.codon_valid;
		res_n.codon_rare    = op_s2.codon_rare;
		res_n.total_codons  = op_s2.total_codons;
		res_n.gc_count      = op_s2.gc_count;
		res_n.base_count    = op_s2.base_count;
		res_n.rare_distinct = op_s2.rare_distinct;
		if (op_s2.op == OP_READ) begin
			res_n.result_kind = KIND_READ;
			res_n.bin_count   = cur_bin;
		end else begin
			res_n.result_kind = KIND_TRIPLET;
			res_n.bin_count   = op_s2.codon_valid ? new_bin : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_s2     <= hist_mem[head.addr];
			rd_vld_s2 <= hist_vld_q[head.addr];
			op_s2     <= head;
		end
		if (done_s2 && writes) begin
			hist_mem[op_s2.addr] <= new_bin;
		end
		if (done_s2 && writes) begin
			last_addr_q <= op_s2.addr;
			last_data_q <= new_bin;
		end
		if (done_s2 && emits) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2     <= 1'b0;
			hist_vld_q <= '0;
			last_clr_q <= 1'b0;
			last_upd_q <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			if (adv) begin
				vld_s2 <= !empty;
			end
			if (done_s2 && (op_s2.op == OP_CLEAR)) begin
				hist_vld_q <= '0;
				last_clr_q <= 1'b1;
				last_upd_q <= 1'b0;
			end else if (done_s2 && writes) begin
				hist_vld_q[op_s2.addr] <= 1'b1;
				last_clr_q <= 1'b0;
				last_upd_q <= 1'b1;
			end
			if (done_s2 && emits) begin
				res_vld_q <= 1'b1;
			end else if (result_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	`CUC_ASSERT_NEXT(a_back_emit, done_s2 && emits, res_vld_q, "op left no result")
	`CUC_ASSERT_NEXT(a_back_clear_bins, done_s2 && (op_s2.op == OP_CLEAR), hist_vld_q == '0, "bins kept")

endmodule

// ===== src/codon_usage_counter.sv =====
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_ready     item_t (command, base_char, bin_index)
// result    out        result_valid / result_ready result_t (report or read answer)
// config    in         psel, penable, pwrite, ...  rare_codon_mask at byte address 0
//
// A sustained stream of one transfer per cycle is accepted, limited only by the
// four-entry work queue filling up. A result passes through the work queue, the
// histogram memory read, and the increment and output register. Reset clears all
// counters, bin valid flags and the queue at once; no clearing pass. A stalled result
// holds the back part; the front keeps taking items until the queue fills.

`include "codon_usage_counter_macros.svh"

module codon_usage_counter import cuc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               item_valid,
	output logic               item_ready,
	input  item_t              item,

	output logic               result_valid,
	input  logic               result_ready,
	output result_t            result,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// The rare mask is the only register; it sits in the lower 8-byte slot.
	logic [NCODON-1:0] mask_q;
	logic              cfg_wr;
	logic              sel_mask;

	// Front to queue, queue to back.
	logic              accept;
	logic              q_push;
	logic              q_pop;
	logic              q_empty;
	logic              q_full;
	back_op_t          q_wr_op;
	back_op_t          q_head;

	assign pready   = 1'b1;
	assign sel_mask = (paddr[PADDR_W-1] == 1'b0);
	assign cfg_wr   = psel && penable && pwrite && pready && sel_mask;
	assign prdata   = sel_mask ? mask_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= RARE_MASK_RESET;
		end else if (cfg_wr) begin
			mask_q <= pwdata;
		end
	end

	// The front part is always able to take an item while the queue has room,
	// whether or not the item will need any work from the back part.
	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;

	cuc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.rare_mask (mask_q),
		.push      (q_push),
		.wr_op     (q_wr_op)
	);

	cuc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_op  (q_wr_op),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty),
		.full   (q_full)
	);

	// The back part owns the histogram memory and the output register.
	cuc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.empty        (q_empty),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Work is only ever queued for an item that was accepted.
	`CUC_ASSERT_NOW(a_top_push_on_accept, q_push, accept, "work queued without an accepted transfer")

endmodule
